@@ rtl/core/sphc_pkg.sv @@
// Shared types and constants for the sphere pair collision detector.
package sphc_pkg;

  // Field widths of one sphere beat
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 23;
  localparam int SPHERE_W  = 3 * COORD_W + RAD_W;
  localparam int S_TDATA_W = 96;

  // Result beat
  localparam int IDX_OUT_W = 6;
  localparam int M_TDATA_W = 16;

  // Datapath widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int DIST_W = SQ_W + 2;
  localparam int RSUM_W = RAD_W + 1;
  localparam int RSQ_W  = 2 * RSUM_W;

  // Control sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_OVF
  } state_t;

endpackage

@@ rtl/core/sphc_ram.sv @@
// Generic simple dual-port RAM with registered read and read enable.
module sphc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sphere_pair_collision_detect.sv @@
// Top level: all-pairs sphere collision detector over a sphere memory.
//
//  channel | dir | fields
//  s_*     | in  | tdata: centre_x, centre_y, centre_z, sphere_radius; tuser: start_set
//  m_*     | out | tdata: earlier_index, later_index; tlast: last_of_run; tuser: overflow
//
// For a sphere arriving at a set of n stored spheres, the memory read port walks the
// stored entries one per cycle, while no stall holds it, into a four-stage distance
// pipeline, then the pipeline drains and the held last hit, if any, goes out.
// Reset clears the sphere count and control state only; the memory needs no clearing.
// When a new hit meets the held one while the result output is stalled, the whole
// compare pipeline, memory read included, freezes until the held hit can move on.
module sphere_pair_collision_detect #(
  parameter int MAX_SPHERES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [23:0] centre_x, [47:24] centre_y, [71:48] centre_z, [94:72] sphere_radius
  input  logic [sphc_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] start_set
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [5:0] earlier_index, [11:6] later_index
  output logic [sphc_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  // [0] overflow
  output logic                           m_tuser
);

  localparam int IW  = $clog2(MAX_SPHERES);
  localparam int CW  = $clog2(MAX_SPHERES + 1);
  localparam int OW  = sphc_pkg::IDX_OUT_W;
  localparam int CRW = sphc_pkg::COORD_W;
  localparam int RW  = sphc_pkg::RAD_W;
  localparam int DW  = sphc_pkg::DIFF_W;
  localparam int QW  = sphc_pkg::SQ_W;
  localparam int SW  = sphc_pkg::DIST_W;
  localparam int RSW = sphc_pkg::RSUM_W;
  localparam int RQW = sphc_pkg::RSQ_W;
  localparam int PW  = sphc_pkg::SPHERE_W;

  sphc_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] n_eff;
  logic          in_beat;
  logic          is_ovf;

  // Current sphere under test
  logic signed [CRW-1:0] cur_x, cur_y, cur_z;
  logic [RW-1:0]         cur_r;
  logic [IW-1:0]         cur_idx;
  logic [IW-1:0]         last_idx;

  // Scan and pipeline
  logic [IW-1:0]         rd_idx;
  logic [PW-1:0]         rd_data;
  logic                  adv;
  logic                  issue;
  logic                  v1, v2, v3, v4;
  logic [IW-1:0]         i1, i2, i3, i4;
  logic signed [CRW-1:0] sx, sy, sz;
  logic [RW-1:0]         sr;
  logic signed [DW-1:0]  dx, dy, dz;
  logic [RSW-1:0]        rsum;
  logic signed [2*DW-1:0] px, py, pz;
  logic [QW-1:0]         qx, qy, qz;
  logic [RQW-1:0]        rsq3, rsq4;
  logic [SW-1:0]         dist4;
  logic                  hit;

  // Held hit, so the final one of a run can be marked
  logic          pend_valid;
  logic [IW-1:0] pend_idx;

  // Output register control
  logic out_free;
  logic pair_emit;
  logic flush_emit;
  logic ovf_emit;

  // Sphere memory: x, y, z, radius packed as on the input beat
  sphc_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_SPHERES)
  ) u_ram (
    .clk   (clk),
    .we    (in_beat && !is_ovf),
    .waddr (n_eff[IW-1:0]),
    .wdata (s_tdata[PW-1:0]),
    .re    (adv),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // Set bookkeeping for the incoming beat
  assign in_beat = s_tvalid && s_tready;
  assign n_eff   = s_tuser ? '0 : count;
  assign is_ovf  = (n_eff >= CW'(MAX_SPHERES));

  // Compare result and stall
  assign out_free = !m_tvalid || m_tready;
  assign hit      = v4 && (dist4 < SW'(rsq4));
  assign adv      = !(hit && pend_valid && !out_free);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sphc_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (is_ovf) begin
            state_next = sphc_pkg::ST_OVF;
          end else if (n_eff != '0) begin
            state_next = sphc_pkg::ST_SCAN;
          end
        end
      end
      sphc_pkg::ST_SCAN: begin
        if (adv && rd_idx == last_idx) begin
          state_next = sphc_pkg::ST_DRAIN;
        end
      end
      sphc_pkg::ST_DRAIN: begin
        if (!(v1 || v2 || v3 || v4)) begin
          state_next = sphc_pkg::ST_FLUSH;
        end
      end
      sphc_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = sphc_pkg::ST_IDLE;
        end
      end
      sphc_pkg::ST_OVF: begin
        if (out_free) begin
          state_next = sphc_pkg::ST_IDLE;
        end
      end
      default: state_next = sphc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready   = 1'b0;
    issue      = 1'b0;
    flush_emit = 1'b0;
    ovf_emit   = 1'b0;
    case (state)
      sphc_pkg::ST_IDLE:  s_tready   = 1'b1;
      sphc_pkg::ST_SCAN:  issue      = adv;
      sphc_pkg::ST_DRAIN: issue      = 1'b0;
      sphc_pkg::ST_FLUSH: flush_emit = pend_valid && out_free;
      sphc_pkg::ST_OVF:   ovf_emit   = out_free;
      default:            s_tready   = 1'b0;
    endcase
  end

  assign pair_emit = hit && pend_valid && out_free;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sphc_pkg::ST_IDLE;
      count      <= '0;
      rd_idx     <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        count  <= is_ovf ? count : n_eff + CW'(1);
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + IW'(1);
      end
      if (adv) begin
        v1 <= (state == sphc_pkg::ST_SCAN);
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
      if (hit && adv) begin
        pend_valid <= 1'b1;
      end else if (flush_emit) begin
        pend_valid <= 1'b0;
      end
      if (pair_emit || flush_emit || ovf_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Latch the sphere under test
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_x    <= s_tdata[CRW-1:0];
      cur_y    <= s_tdata[2*CRW-1:CRW];
      cur_z    <= s_tdata[3*CRW-1:2*CRW];
      cur_r    <= s_tdata[PW-1:3*CRW];
      cur_idx  <= n_eff[IW-1:0];
      last_idx <= IW'(n_eff - CW'(1));
    end
  end

  // Stored sphere fields from the memory
  assign sx = rd_data[CRW-1:0];
  assign sy = rd_data[2*CRW-1:CRW];
  assign sz = rd_data[3*CRW-1:2*CRW];
  assign sr = rd_data[PW-1:3*CRW];

  // Squares: one multiplier per axis, registered before the sum
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // Distance pipeline: differences, squares, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      i1 <= rd_idx;
      // differences and radius sum
      i2   <= i1;
      dx   <= DW'(cur_x) - DW'(sx);
      dy   <= DW'(cur_y) - DW'(sy);
      dz   <= DW'(cur_z) - DW'(sz);
      rsum <= RSW'(cur_r) + RSW'(sr);
      // squares
      i3   <= i2;
      qx   <= px[QW-1:0];
      qy   <= py[QW-1:0];
      qz   <= pz[QW-1:0];
      rsq3 <= RQW'(rsum) * RQW'(rsum);
      // squared distance
      i4    <= i3;
      dist4 <= SW'(qx) + SW'(qy) + SW'(qz);
      rsq4  <= rsq3;
    end
    if (hit && adv) begin
      pend_idx <= i4;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (pair_emit) begin
      m_tdata <= {{(sphc_pkg::M_TDATA_W - 2*OW){1'b0}}, OW'(cur_idx), OW'(pend_idx)};
      m_tlast <= 1'b0;
      m_tuser <= 1'b0;
    end else if (flush_emit) begin
      m_tdata <= {{(sphc_pkg::M_TDATA_W - 2*OW){1'b0}}, OW'(cur_idx), OW'(pend_idx)};
      m_tlast <= 1'b1;
      m_tuser <= 1'b0;
    end else if (ovf_emit) begin
      m_tdata <= '0;
      m_tlast <= 1'b1;
      m_tuser <= 1'b1;
    end
  end

endmodule

@@ verif/sphc_pair_checker.sv @@
// Checker for the sphere pair collision detector: predicts hits per sphere and compares beats.
`timescale 1ns / 1ps

module sphc_pair_checker #(
  parameter int MAX_SPHERES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [sphc_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [sphc_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           m_tlast,
  input  logic                           m_tuser,
  output int                             mismatches,
  output int                             hits_pending
);
  localparam int IDX_OUT_W = sphc_pkg::IDX_OUT_W;
  localparam int COORD_W   = sphc_pkg::COORD_W;
  localparam int RAD_W     = sphc_pkg::RAD_W;
  localparam int M_TDATA_W = sphc_pkg::M_TDATA_W;

  // One expected result beat
  typedef struct packed {
    logic [IDX_OUT_W-1:0] earlier_index;
    logic [IDX_OUT_W-1:0] later_index;
    logic                 last_of_run;
    logic                 overflow;
  } hit_t;

  // Shadow copy of the sphere store
  logic signed [COORD_W-1:0] held_x [MAX_SPHERES];
  logic signed [COORD_W-1:0] held_y [MAX_SPHERES];
  logic signed [COORD_W-1:0] held_z [MAX_SPHERES];
  logic        [RAD_W-1:0]   held_r [MAX_SPHERES];
  int unsigned               held_count;

  hit_t hits_due [$];

  initial begin
    mismatches   = 0;
    hits_pending = 0;
    held_count   = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 100)
      $display("%0t ns  collision check: %s", $realtime, what);
    mismatches++;
  endtask

  // Test a new sphere against the held set, queue its hits, then store it
  task automatic predict_sphere(input logic new_set, input logic signed [COORD_W-1:0] cx,
                                input logic signed [COORD_W-1:0] cy,
                                input logic signed [COORD_W-1:0] cz,
                                input logic [RAD_W-1:0] cr);
    longint dx, dy, dz, gap2, rsum;
    int     hits;
    hit_t   h;
    hits = 0;
    if (new_set)
      held_count = 0;
    // full store: sphere dropped, single flagged beat
    if (held_count >= MAX_SPHERES) begin
      h = '{earlier_index: '0, later_index: '0, last_of_run: 1'b1, overflow: 1'b1};
      hits_due = {hits_due, h};
      return;
    end
    for (int i = 0; i < held_count; i++) begin
      dx   = longint'(cx) - longint'(held_x[i]);
      dy   = longint'(cy) - longint'(held_y[i]);
      dz   = longint'(cz) - longint'(held_z[i]);
      gap2 = dx * dx + dy * dy + dz * dz;
      rsum = longint'(cr) + longint'(held_r[i]);
      // strict: touching spheres do not collide
      if (gap2 < rsum * rsum) begin
        h = '{earlier_index: IDX_OUT_W'(i), later_index: IDX_OUT_W'(held_count),
              last_of_run: 1'b0, overflow: 1'b0};
        hits_due = {hits_due, h};
        hits++;
      end
    end
    if (hits > 0)
      hits_due[hits_due.size() - 1].last_of_run = 1'b1;
    held_x[held_count] = cx;
    held_y[held_count] = cy;
    held_z[held_count] = cz;
    held_r[held_count] = cr;
    held_count++;
  endtask

  // Compare one result beat with the oldest expected hit
  task automatic check_beat();
    hit_t want;
    if (hits_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b tuser=%b",
                                m_tdata, m_tlast, m_tuser));
      return;
    end
    want = hits_due[0];
    hits_due.delete(0);
    if (m_tdata[5:0] != want.earlier_index)
      report_mismatch($sformatf("earlier_index %0d, want %0d", m_tdata[5:0],
                                want.earlier_index));
    if (m_tdata[11:6] != want.later_index)
      report_mismatch($sformatf("later_index %0d, want %0d", m_tdata[11:6],
                                want.later_index));
    if (m_tlast != want.last_of_run)
      report_mismatch($sformatf("last_of_run %b, want %b (pair %0d,%0d)", m_tlast,
                                want.last_of_run, want.earlier_index, want.later_index));
    if (m_tuser != want.overflow)
      report_mismatch($sformatf("overflow %b, want %b", m_tuser, want.overflow));
    if (m_tdata[M_TDATA_W-1:12] != '0)
      report_mismatch($sformatf("tdata padding not zero: %h", m_tdata));
  endtask

  // Watch both channels; outputs before inputs, since a hit never leaves on its own beat
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
    end else begin
      if (m_tvalid && m_tready)
        check_beat();
      if (s_tvalid && s_tready)
        predict_sphere(s_tuser, s_tdata[23:0], s_tdata[47:24], s_tdata[71:48],
                       s_tdata[94:72]);
    end
    hits_pending <= hits_due.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the sphere pair collision detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  localparam int S_TDATA_W = sphc_pkg::S_TDATA_W;
  localparam int M_TDATA_W = sphc_pkg::M_TDATA_W;
  localparam int COORD_W   = sphc_pkg::COORD_W;
  localparam int RAD_W     = sphc_pkg::RAD_W;

  localparam int MAX_SPHERES  = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 150;
  localparam int CALM_FROM    = 200;
  localparam int CALM_TO      = 300;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 calm     = 1'b0;
  int                   spheres_sent = 0;
  int                   cycles       = 0;
  int                   mismatches;
  int                   hits_pending;

  always #2 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sphere_pair_collision_detect: mismatch");
      $finish;
    end
  end

  // Result side backpressure, off during the calm stretch
  always @(posedge clk)
    m_tready <= calm || ($urandom_range(0, 99) >= 19);

  sphere_pair_collision_detect #(.MAX_SPHERES(MAX_SPHERES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  sphc_pair_checker #(.MAX_SPHERES(MAX_SPHERES)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .hits_pending (hits_pending)
  );

  // Drive one sphere beat, with random idle cycles ahead of it outside the calm stretch
  task automatic send_sphere(input logic new_set, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                             input logic [RAD_W-1:0] r);
    logic quiet;
    quiet = (spheres_sent >= CALM_FROM) && (spheres_sent < CALM_TO);
    calm <= quiet;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 19) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, r, z, y, x};
    s_tuser  <= new_set;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    spheres_sent++;
  endtask

  // Signed offset in [-2^(span-1), 2^(span-1)), as 24-bit two's complement
  function automatic logic [COORD_W-1:0] jitter(input int unsigned span);
    return COORD_W'($urandom_range(0, (1 << span) - 1)) - COORD_W'(1 << (span - 1));
  endfunction

  // Radius on the cluster's scale, now and then zero or full scale
  function automatic logic [RAD_W-1:0] pick_radius(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 31);
    if (roll == 0)
      return '0;
    if (roll == 1)
      return {RAD_W{1'b1}};
    return RAD_W'($urandom_range(0, 1 << (span - 1)));
  endfunction

  // A well-formed set: spheres packed around one random point
  task automatic send_cluster(input int members);
    logic [COORD_W-1:0] bx, by, bz;
    int unsigned        span;
    span = $urandom_range(4, 22);
    bx   = COORD_W'($urandom);
    by   = COORD_W'($urandom);
    bz   = COORD_W'($urandom);
    for (int k = 0; k < members; k++)
      send_sphere(k == 0, bx + jitter(span), by + jitter(span), bz + jitter(span),
                  pick_radius(span));
  endtask

  initial begin
    int roll;
    int members;
    int set_no;
    int random_start;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty store right after reset, no start flag
    send_sphere(1'b0, 24'h000000, 24'h000000, 24'h000000, 23'd0);
    // same centre, zero radii: distance 0 is not below 0
    send_sphere(1'b0, 24'h000000, 24'h000000, 24'h000000, 23'd0);
    // same centre, tiny radius: hits both
    send_sphere(1'b0, 24'h000000, 24'h000000, 24'h000000, 23'd1);
    // corners of the coordinate range with full radius
    send_sphere(1'b1, 24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF);
    send_sphere(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
    send_sphere(1'b0, 24'h000000, 24'h000000, 24'h000000, 23'h7FFFFF);
    // exact touch misses, one step closer hits
    send_sphere(1'b1, 24'd0, 24'd0, 24'd0, 23'd256);
    send_sphere(1'b0, 24'd512, 24'd0, 24'd0, 23'd256);
    send_sphere(1'b0, 24'd511, 24'd0, 24'd0, 23'd256);
    // mixed signs, radius one below and at the hit threshold
    send_sphere(1'b1, -24'd100, 24'd200, -24'd300, 23'd50);
    send_sphere(1'b0, 24'd100, -24'd200, 24'd300, 23'd698);
    send_sphere(1'b0, 24'd100, -24'd200, 24'd300, 23'd699);
    // alternating bit patterns
    send_sphere(1'b1, 24'h555555, 24'hAAAAAA, 24'h555555, 23'h2AAAAA);
    send_sphere(1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 23'h555555);
    send_sphere(1'b0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 23'd1);

    // random sets; an early big one fills the store and overflows
    set_no       = 0;
    random_start = spheres_sent;
    while (spheres_sent - random_start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (set_no == 2)
        members = 67;
      else if (roll < 4)
        members = $urandom_range(62, 68);
      else if (roll < 80)
        members = $urandom_range(2, 12);
      else
        members = 0;
      if (members > 0)
        send_cluster(members);
      else
        send_sphere(1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
                    COORD_W'($urandom), RAD_W'($urandom));
      set_no++;
    end
    s_tvalid <= 1'b0;

    // drain outstanding hits, then watch for strays
    @(posedge clk);
    while (hits_pending != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("sphere_pair_collision_detect: match");
    else
      $display("sphere_pair_collision_detect: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sphc_pkg.sv
rtl/core/sphc_ram.sv
rtl/core/sphere_pair_collision_detect.sv
verif/sphc_pair_checker.sv
verif/tb_top.sv
